### rtl/svalloc_pkg.sv
// Shared types and constants for the sound voice allocator.
// No dependencies; imported by sound_voice_allocator_core.
package svalloc_pkg;

    localparam int SAMPLE_IDS_DEF       = 1024;
    localparam int SLOT_COUNT_DEF       = 256;
    localparam int LOOP_VOICES_DEF      = 4;
    localparam int ONESHOT_CHANNELS_DEF = 9;

    localparam int ONESHOT_LO = 3;
    localparam int LOOP_LO    = 12;
    localparam int STOPALL_HI = 15;

    localparam int ID_W     = 10;
    localparam int SLOT_W_O = 8;
    localparam int CH_W     = 4;
    localparam int VOL_W    = 8;
    localparam int HANDLE_W = 31;

    localparam logic signed [1:0] TIER_UNKNOWN = 2'sb11;
    localparam logic signed [1:0] TIER_DIGITAL = 2'sb01;

    localparam logic REG_AUDIO_TIER = 1'b0;

    typedef enum logic [1:0] {
        FN_PLAY     = 2'd0,
        FN_LOOP     = 2'd1,
        FN_STOP     = 2'd2,
        FN_STOP_ALL = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CMD_STORE = 3'd0,
        CMD_LOAD  = 3'd1,
        CMD_QUEUE = 3'd2,
        CMD_FLUSH = 3'd3,
        CMD_DONE  = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEAL,
        ST_STORE,
        ST_LOAD,
        ST_QUEUE,
        ST_STOP,
        ST_STOP_ALL,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t                  command;
        logic [ID_W-1:0]       sample_ref;
        logic [SLOT_W_O-1:0]   slot_number;
        logic [CH_W-1:0]       channel_number;
        logic [VOL_W-1:0]      queue_volume;
        logic [7:0]            queue_pan;
        logic                  looped;
        logic [HANDLE_W-1:0]   new_handle;
        logic                  last;
    } out_item_t;

    typedef struct packed {
        logic take_slot;
        logic queue_oneshot;
        logic queue_loop;
        logic voice_free;
        logic voice_free_all;
        logic ch_step;
    } upd_t;

endpackage

### rtl/sound_voice_allocator_core.sv
// Sound voice allocator: turns sound requests into store/load/queue/flush commands.
// Uses svalloc_pkg. Holds the sample-stored bitmap in a one-port synchronous memory.
//
// Each request is taken in the idle state and produces a burst of commands closed by
// one done transfer (m_last high). Requests are handled one at a time: the sequencer
// holds one state per result transfer and waits in it while the output is stalled; on
// play and loop start the store state passes on without a transfer when the sample is
// already stored, and after the done transfer the sequencer returns to idle.
// The upload-once bitmap lives in a memory with a registered read issued at the input
// transfer. After reset the block clears that memory, one entry per cycle, through all
// SAMPLE_IDS entries; s_ready stays low meanwhile, APB writes are taken throughout.
// Requests do nothing but return done unless audio_tier holds 1 (digital).
module sound_voice_allocator_core #(
    parameter int SAMPLE_IDS       = svalloc_pkg::SAMPLE_IDS_DEF,
    parameter int SLOT_COUNT       = svalloc_pkg::SLOT_COUNT_DEF,
    parameter int LOOP_VOICES      = svalloc_pkg::LOOP_VOICES_DEF,
    parameter int ONESHOT_CHANNELS = svalloc_pkg::ONESHOT_CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [9:0]         s_sound_id,
    input  logic               s_data_present,
    input  logic [7:0]         s_volume,
    input  logic signed [7:0]  s_pan,
    input  logic [30:0]        s_stop_handle,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_command,
    output logic [9:0]         m_sample_ref,
    output logic [7:0]         m_slot_number,
    output logic [3:0]         m_channel_number,
    output logic [7:0]         m_queue_volume,
    output logic signed [7:0]  m_queue_pan,
    output logic               m_looped,
    output logic [30:0]        m_new_handle,
    output logic               m_last
);
    import svalloc_pkg::*;

    localparam int SID_W   = $clog2(SAMPLE_IDS);
    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int VOICE_W = (LOOP_VOICES > 1) ? $clog2(LOOP_VOICES) : 1;

    localparam logic [SID_W-1:0]  CLR_LAST  = SID_W'(SAMPLE_IDS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [CH_W-1:0]   OS_FIRST  = CH_W'(ONESHOT_LO);
    localparam logic [CH_W-1:0]   OS_LAST   = CH_W'(ONESHOT_LO + ONESHOT_CHANNELS - 1);
    localparam logic [CH_W-1:0]   SA_LAST   = CH_W'(STOPALL_HI);

    // configuration
    logic signed [1:0] tier_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_AUDIO_TIER);
    assign prdata = (paddr[2] == REG_AUDIO_TIER) ? {{30{tier_reg[1]}}, tier_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tier_reg <= TIER_UNKNOWN;
        end else if (cfg_wr) begin
            tier_reg <= pwdata[1:0];
        end
    end

    // state
    state_t                state_reg, state_next;
    logic [SID_W-1:0]      clr_idx_reg;
    logic [SLOT_W-1:0]     slot_cursor_reg;
    logic [CH_W-1:0]       os_cursor_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [HANDLE_W-1:0]   voice_reg [LOOP_VOICES];

    // request context
    func_t                 func_reg;
    logic [ID_W-1:0]       id_reg;
    logic [SID_W-1:0]      idx_reg;
    logic [VOL_W-1:0]      vol_reg;
    logic [7:0]            pan_reg;
    logic [VOICE_W-1:0]    vidx_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [CH_W-1:0]       ch_reg;
    logic [HANDLE_W-1:0]   result_reg;

    // memory
    logic                  sample_stored_reg [SAMPLE_IDS];
    logic                  rd_stored_reg;
    logic                  mem_we;
    logic                  mem_wdata;
    logic [SID_W-1:0]      mem_waddr;
    logic [SID_W-1:0]      s_idx;

    // output register
    logic                  m_valid_reg;
    out_item_t             m_item_reg;

    logic                  s_accept;
    logic                  out_free;
    logic                  emit;
    out_item_t             item;
    upd_t                  upd;
    logic                  req_ok;
    logic                  free_found, match_found;
    logic [VOICE_W-1:0]    free_idx, match_idx;
    logic [HANDLE_W-1:0]   handle_inc, handle_new;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_idx    = SID_W'(32'(s_sound_id));
    assign req_ok   = s_data_present && (32'(s_sound_id) < SAMPLE_IDS);

    assign handle_inc = handle_reg + 1'b1;
    assign handle_new = (handle_inc == '0) ? HANDLE_W'(1) : handle_inc;

    always_comb begin
        free_found  = 1'b0;
        free_idx    = '0;
        match_found = 1'b0;
        match_idx   = '0;
        for (int i = LOOP_VOICES - 1; i >= 0; i--) begin
            if (voice_reg[i] == '0) begin
                free_found = 1'b1;
                free_idx   = VOICE_W'(i);
            end
            if (voice_reg[i] == s_stop_handle) begin
                match_found = 1'b1;
                match_idx   = VOICE_W'(i);
            end
        end
        if (s_stop_handle == '0) begin
            match_found = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        emit       = 1'b0;
        item       = '0;
        upd        = '0;
        mem_we     = 1'b0;
        mem_wdata  = 1'b0;
        mem_waddr  = idx_reg;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                if (clr_idx_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (tier_reg != TIER_DIGITAL) begin
                        state_next = ST_DONE;
                    end else begin
                        case (func_t'(s_func))
                            FN_PLAY:     state_next = req_ok ? ST_STORE : ST_DONE;
                            FN_LOOP:     state_next = !req_ok ? ST_DONE :
                                                      (free_found ? ST_STORE : ST_STEAL);
                            FN_STOP:     state_next = match_found ? ST_STOP : ST_DONE;
                            FN_STOP_ALL: state_next = ST_STOP_ALL;
                            default:     state_next = ST_DONE;
                        endcase
                    end
                end
            end
            ST_STEAL: begin
                item.command        = CMD_FLUSH;
                item.channel_number = CH_W'(LOOP_LO);
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                item.command    = CMD_STORE;
                item.sample_ref = id_reg;
                if (rd_stored_reg) begin
                    state_next = ST_LOAD;
                end else if (out_free) begin
                    emit       = 1'b1;
                    mem_we     = 1'b1;
                    mem_wdata  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                item.command     = CMD_LOAD;
                item.sample_ref  = id_reg;
                item.slot_number = SLOT_W_O'(slot_cursor_reg);
                if (out_free) begin
                    emit          = 1'b1;
                    upd.take_slot = 1'b1;
                    state_next    = ST_QUEUE;
                end
            end
            ST_QUEUE: begin
                item.command      = CMD_QUEUE;
                item.slot_number  = SLOT_W_O'(slot_reg);
                item.queue_volume = vol_reg;
                if (func_reg == FN_PLAY) begin
                    item.channel_number = os_cursor_reg;
                    item.queue_pan      = pan_reg;
                end else begin
                    item.channel_number = CH_W'(LOOP_LO + int'(vidx_reg));
                    item.looped         = 1'b1;
                end
                if (out_free) begin
                    emit              = 1'b1;
                    upd.queue_oneshot = (func_reg == FN_PLAY);
                    upd.queue_loop    = (func_reg != FN_PLAY);
                    state_next        = ST_DONE;
                end
            end
            ST_STOP: begin
                item.command        = CMD_FLUSH;
                item.channel_number = CH_W'(LOOP_LO + int'(vidx_reg));
                if (out_free) begin
                    emit           = 1'b1;
                    upd.voice_free = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_STOP_ALL: begin
                item.command        = CMD_FLUSH;
                item.channel_number = ch_reg;
                if (out_free) begin
                    emit        = 1'b1;
                    upd.ch_step = 1'b1;
                    if (ch_reg == SA_LAST) begin
                        upd.voice_free_all = 1'b1;
                        state_next         = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                item.command    = CMD_DONE;
                item.new_handle = result_reg;
                item.last       = 1'b1;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // bitmap memory; one request in flight, so the store write always precedes the next read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sample_stored_reg[mem_waddr] <= mem_wdata;
        end
        if (s_accept) begin
            rd_stored_reg <= sample_stored_reg[s_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg     <= '0;
            slot_cursor_reg <= SLOT_W'(1);
            os_cursor_reg   <= OS_FIRST;
            handle_reg      <= '0;
            for (int i = 0; i < LOOP_VOICES; i++) begin
                voice_reg[i] <= '0;
            end
        end else begin
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (upd.take_slot) begin
                slot_cursor_reg <= (slot_cursor_reg == SLOT_LAST) ? SLOT_W'(1)
                                                                  : slot_cursor_reg + 1'b1;
            end
            if (upd.queue_oneshot) begin
                os_cursor_reg <= (os_cursor_reg == OS_LAST) ? OS_FIRST : os_cursor_reg + 1'b1;
            end
            if (upd.queue_loop) begin
                handle_reg          <= handle_new;
                voice_reg[vidx_reg] <= handle_new;
            end
            if (upd.voice_free) begin
                voice_reg[vidx_reg] <= '0;
            end
            if (upd.voice_free_all) begin
                for (int i = 0; i < LOOP_VOICES; i++) begin
                    voice_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg   <= func_t'(s_func);
            id_reg     <= s_sound_id;
            idx_reg    <= s_idx;
            vol_reg    <= s_volume;
            pan_reg    <= s_pan;
            vidx_reg   <= (func_t'(s_func) == FN_STOP) ? match_idx
                                                       : (free_found ? free_idx : '0);
            ch_reg     <= OS_FIRST;
            result_reg <= '0;
        end else begin
            if (upd.ch_step) begin
                ch_reg <= ch_reg + 1'b1;
            end
            if (upd.take_slot) begin
                slot_reg <= slot_cursor_reg;
            end
            if (upd.queue_loop) begin
                result_reg <= handle_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_item_reg <= item;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_command        = m_item_reg.command;
    assign m_sample_ref     = m_item_reg.sample_ref;
    assign m_slot_number    = m_item_reg.slot_number;
    assign m_channel_number = m_item_reg.channel_number;
    assign m_queue_volume   = m_item_reg.queue_volume;
    assign m_queue_pan      = $signed(m_item_reg.queue_pan);
    assign m_looped         = m_item_reg.looped;
    assign m_new_handle     = m_item_reg.new_handle;
    assign m_last           = m_item_reg.last;

    a_last_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_command == CMD_DONE)))
        else $error("last flag and done command disagree");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != ST_IDLE))
        else $error("request accepted without a done transfer");

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("request taken during memory clear");

    a_slot_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_cursor_reg != '0)
        else $error("slot cursor reached slot zero");

    a_handle_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        upd.queue_loop |=> (handle_reg != '0) && (result_reg == handle_reg))
        else $error("loop start produced a null handle");

endmodule

### tb/sound_voice_allocator_core_tb.sv
// Self-checking testbench for sound_voice_allocator_core: directed and random sound requests,
// audio tier writes over APB, and a command predictor with its own copy of the voice state.
// Depends on svalloc_pkg and the RTL top level only.
`timescale 1ns / 100ps

module sound_voice_allocator_core_tb;
    import svalloc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic signed [1:0] TIER_TONE = 2'sb00;

    typedef struct {
        func_t             func;
        logic [9:0]        id;
        logic              dp;
        logic [7:0]        vol;
        logic signed [7:0] pan;
        logic [30:0]       hstop;
    } sound_req_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_func = '0;
    logic [9:0]         s_sound_id = '0;
    logic               s_data_present = 1'b0;
    logic [7:0]         s_volume = '0;
    logic signed [7:0]  s_pan = '0;
    logic [30:0]        s_stop_handle = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_command;
    logic [9:0]         m_sample_ref;
    logic [7:0]         m_slot_number;
    logic [3:0]         m_channel_number;
    logic [7:0]         m_queue_volume;
    logic signed [7:0]  m_queue_pan;
    logic               m_looped;
    logic [30:0]        m_new_handle;
    logic               m_last;

    sound_voice_allocator_core u_top (.*);

    always #10 aclk = ~aclk;

    sound_req_t req_q[$];
    out_item_t  cmd_expect_q[$];

    // predictor state
    logic signed [1:0] tier_now = TIER_UNKNOWN;
    bit                sample_seen [SAMPLE_IDS_DEF];
    int                slot_cur = 1;
    int                ch_cur = ONESHOT_LO;
    logic [30:0]       voice_handle_q [LOOP_VOICES_DEF];
    logic [30:0]       handle_cnt = '0;

    int  err_cnt = 0;
    int  cycle_cnt = 0;
    int  loops_made = 0;
    bit  no_idle = 1'b0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;
    int  tx_gap = 0;
    int  rx_stall = 0;
    logic req_taken = 1'b0;

    initial begin
        for (int i = 0; i < LOOP_VOICES_DEF; i++) voice_handle_q[i] = '0;
    end

    function automatic void push_cmd(cmd_t cmd, int sref, int slot, int ch, logic [7:0] vol,
                                     logic [7:0] pan, logic lp, logic [30:0] h, logic lst);
        out_item_t c;
        c.command        = cmd;
        c.sample_ref     = ID_W'(sref);
        c.slot_number    = SLOT_W_O'(slot);
        c.channel_number = CH_W'(ch);
        c.queue_volume   = vol;
        c.queue_pan      = pan;
        c.looped         = lp;
        c.new_handle     = h;
        c.last           = lst;
        cmd_expect_q.push_back(c);
    endfunction

    function automatic void store_once(logic [9:0] id);
        if (!sample_seen[id]) begin
            push_cmd(CMD_STORE, int'(id), 0, 0, 8'd0, 8'd0, 1'b0, '0, 1'b0);
            sample_seen[id] = 1'b1;
        end
    endfunction

    function automatic int claim_patch_slot();
        int s;
        s = slot_cur;
        slot_cur = 1 + (slot_cur % (SLOT_COUNT_DEF - 1));
        return s;
    endfunction

    function automatic void allocate_voices(sound_req_t r);
        int          slot;
        int          v;
        bit          hit;
        logic [30:0] nh;
        nh = '0;
        hit = 1'b0;
        if (tier_now == TIER_DIGITAL) begin
            case (r.func)
                FN_PLAY: begin
                    if (r.dp && 32'(r.id) < SAMPLE_IDS_DEF) begin
                        store_once(r.id);
                        slot = claim_patch_slot();
                        push_cmd(CMD_LOAD, int'(r.id), slot, 0, 8'd0, 8'd0, 1'b0, '0, 1'b0);
                        push_cmd(CMD_QUEUE, 0, slot, ch_cur, r.vol, r.pan, 1'b0, '0, 1'b0);
                        ch_cur = ONESHOT_LO + ((ch_cur - ONESHOT_LO + 1) % ONESHOT_CHANNELS_DEF);
                    end
                end
                FN_LOOP: begin
                    if (r.dp && 32'(r.id) < SAMPLE_IDS_DEF) begin
                        v = 0;
                        while (v < LOOP_VOICES_DEF && voice_handle_q[v] != '0) v++;
                        if (v == LOOP_VOICES_DEF) begin
                            push_cmd(CMD_FLUSH, 0, 0, LOOP_LO, 8'd0, 8'd0, 1'b0, '0, 1'b0);
                            v = 0;
                        end
                        store_once(r.id);
                        slot = claim_patch_slot();
                        push_cmd(CMD_LOAD, int'(r.id), slot, 0, 8'd0, 8'd0, 1'b0, '0, 1'b0);
                        push_cmd(CMD_QUEUE, 0, slot, LOOP_LO + v, r.vol, 8'd0, 1'b1, '0, 1'b0);
                        handle_cnt = handle_cnt + 31'd1;
                        if (handle_cnt == '0) handle_cnt = 31'd1;
                        voice_handle_q[v] = handle_cnt;
                        nh = handle_cnt;
                    end
                end
                FN_STOP: begin
                    if (r.hstop != '0) begin
                        for (int i = 0; i < LOOP_VOICES_DEF; i++) begin
                            if (!hit && voice_handle_q[i] == r.hstop) begin
                                hit = 1'b1;
                                push_cmd(CMD_FLUSH, 0, 0, LOOP_LO + i, 8'd0, 8'd0, 1'b0, '0,
                                         1'b0);
                                voice_handle_q[i] = '0;
                            end
                        end
                    end
                end
                default: begin
                    for (int ch = ONESHOT_LO; ch <= STOPALL_HI; ch++)
                        push_cmd(CMD_FLUSH, 0, 0, ch, 8'd0, 8'd0, 1'b0, '0, 1'b0);
                    for (int i = 0; i < LOOP_VOICES_DEF; i++) voice_handle_q[i] = '0;
                end
            endcase
        end
        push_cmd(CMD_DONE, 0, 0, 0, 8'd0, 8'd0, 1'b0, nh, 1'b1);
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            err_cnt++;
        end
    endtask

    // request driver
    always @(negedge aclk) begin : drv
        sound_req_t nxt;
        if (!s_valid || req_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (!no_idle && !tx_calm && $urandom_range(0, 4) == 0) begin
                tx_gap = $urandom_range(0, 9);
                s_valid <= 1'b0;
            end else if (req_q.size() > 0) begin
                nxt = req_q.pop_front();
                s_func         <= nxt.func;
                s_sound_id     <= nxt.id;
                s_data_present <= nxt.dp;
                s_volume       <= nxt.vol;
                s_pan          <= nxt.pan;
                s_stop_handle  <= nxt.hstop;
                s_valid        <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        if ($urandom_range(0, 149) == 0) tx_calm = !tx_calm;
    end

    // result backpressure
    always @(negedge aclk) begin
        if (no_idle || rx_calm) begin
            m_ready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            rx_stall = $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
        if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
    end

    // monitor: predict on request transfer, check on result transfer
    always @(posedge aclk) begin : mon
        sound_req_t req;
        out_item_t  want;
        if (aresetn && s_valid && s_ready) begin
            req.func  = func_t'(s_func);
            req.id    = s_sound_id;
            req.dp    = s_data_present;
            req.vol   = s_volume;
            req.pan   = s_pan;
            req.hstop = s_stop_handle;
            allocate_voices(req);
            req_taken <= 1'b1;
        end else begin
            req_taken <= 1'b0;
        end
        if (aresetn && m_valid && m_ready) begin
            if (cmd_expect_q.size() == 0) begin
                $error("unexpected transfer: command %0d", m_command);
                err_cnt++;
            end else begin
                want = cmd_expect_q.pop_front();
                check_field("command", 32'(want.command), 32'(m_command));
                check_field("sample_ref", 32'(want.sample_ref), 32'(m_sample_ref));
                check_field("slot_number", 32'(want.slot_number), 32'(m_slot_number));
                check_field("channel_number", 32'(want.channel_number),
                            32'(m_channel_number));
                check_field("queue_volume", 32'(want.queue_volume), 32'(m_queue_volume));
                check_field("queue_pan", 32'(want.queue_pan), 32'(unsigned'(m_queue_pan)));
                check_field("looped", 32'(want.looped), 32'(m_looped));
                check_field("new_handle", 32'(want.new_handle), 32'(m_new_handle));
                check_field("last", 32'(want.last), 32'(m_last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic sound_req_t rand_req();
        sound_req_t r;
        int pick;
        pick    = $urandom_range(0, 99);
        r.func  = pick < 40 ? FN_PLAY : pick < 70 ? FN_LOOP : pick < 92 ? FN_STOP : FN_STOP_ALL;
        r.id    = $urandom_range(0, 1) ? 10'($urandom_range(0, 15)) : 10'($urandom_range(0, 1023));
        r.dp    = $urandom_range(0, 15) != 0;
        r.vol   = 8'($urandom);
        r.pan   = 8'($urandom);
        r.hstop = 31'($urandom);
        if (r.func == FN_LOOP) loops_made++;
        if (r.func == FN_STOP) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) r.hstop = 31'($urandom_range(1, loops_made + 1));
            else if (pick < 75) r.hstop = '0;
        end
        return r;
    endfunction

    task automatic add_req(input func_t f, input int id, input logic dp, input int vol,
                           input int pan, input logic [30:0] h);
        sound_req_t r;
        r.func  = f;
        r.id    = 10'(id);
        r.dp    = dp;
        r.vol   = 8'(vol);
        r.pan   = 8'(pan);
        r.hstop = h;
        req_q.push_back(r);
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++) req_q.push_back(rand_req());
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (req_q.size() != 0 || s_valid || cmd_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic signed [1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_AUDIO_TIER);
        pwdata  <= {{30{val[1]}}, val};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tier_now = val;
    endtask

    initial begin
        aresetn = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // tier unknown after reset, then tone only: done only
        add_random(6);
        wait_drained();
        apb_write(TIER_TONE);
        add_random(6);
        wait_drained();

        apb_write(TIER_DIGITAL);
        add_req(FN_PLAY, 0, 1'b1, 0, -128, '0);
        add_req(FN_PLAY, 1023, 1'b1, 255, 127, 31'h7FFFFFFF);
        add_req(FN_PLAY, 0, 1'b1, 8'h55, 0, '0);
        add_req(FN_PLAY, 7, 1'b0, 8'h10, 5, '0);
        add_req(FN_LOOP, 5, 1'b1, 200, -3, '0);
        add_req(FN_LOOP, 1023, 1'b1, 255, 127, '0);
        add_req(FN_LOOP, 9, 1'b0, 1, 1, '0);
        add_req(FN_LOOP, 10, 1'b1, 17, 0, '0);
        add_req(FN_LOOP, 11, 1'b1, 18, 0, '0);
        add_req(FN_LOOP, 12, 1'b1, 19, 0, '0);
        add_req(FN_STOP, 0, 1'b1, 0, 0, '0);
        add_req(FN_STOP, 0, 1'b1, 0, 0, 31'h7FFFFFFF);
        add_req(FN_STOP, 0, 1'b0, 0, 0, 31'd2);
        add_req(FN_STOP, 0, 1'b0, 0, 0, 31'd2);
        add_req(FN_LOOP, 5, 1'b1, 99, 0, '0);
        add_req(FN_STOP_ALL, 1023, 1'b1, 255, -1, 31'h2AAAAAAA);
        add_req(FN_STOP, 0, 1'b1, 0, 0, 31'd6);
        add_req(FN_PLAY, 512, 1'b1, 1, -1, 31'h55555555);
        add_req(FN_STOP_ALL, 0, 1'b0, 0, 0, '0);
        wait_drained();

        add_random(160);
        wait_drained();
        apb_write(TIER_TONE);
        add_random(10);
        wait_drained();
        apb_write(TIER_UNKNOWN);
        add_random(5);
        wait_drained();
        apb_write(TIER_DIGITAL);
        add_random(160);
        wait_drained();

        no_idle = 1'b1;
        add_random(80);
        wait_drained();

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
